// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the mapper. Each check is sampled on
// the rising clock edge and is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== hdl/slbm_pkg.sv =====
// ----------------------------------------------------------------------------
// slbm_pkg
// Word types and constants shared by the serial-loaded bank mapper.
// ----------------------------------------------------------------------------
package slbm_pkg;

  typedef struct packed {
    logic [3:0] addr_nibble;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0] prg_bank_low;
    logic [3:0] prg_bank_high;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [1:0] mirror_mode;
    logic       ram_enabled;
    logic       ram_bank;
    logic       register_loaded;
  } out_word_t;

  typedef struct packed {
    logic [4:0] control_reg;
    logic [2:0] shift_count;
  } core_status_t;

  localparam logic [1:0] TGT_CONTROL  = 2'd0;
  localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
  localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
  localparam logic [1:0] TGT_PRG      = 2'd3;

  localparam logic [4:0] CTRL_RESET     = 5'h0C;
  localparam logic [4:0] CTRL_RESET_SET = 5'h0C;
  localparam logic [2:0] SHIFT_LAST     = 3'd4;
  localparam logic [2:0] SHIFT_FULL     = 3'd5;

endpackage

// ===== hdl/serial_loaded_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper
// Five-bit serial register bank mapper: one CPU write in, one mapping out.
// ----------------------------------------------------------------------------
// Channel   Ports                          Carries
// req       req_valid, req_ready, req      CPU write word (address nibble, data)
// rsp       rsp_valid, rsp_ready, rsp      bank mapping word after that write
// cfg       cfg_we, cfg_wdata              revision_a rule select
//
// A write word is registered in the input register on acceptance and decoded
// into the result register once that register is free. One word is accepted
// every cycle while the result is not stalled; the latch and decode path is
// combinational. A stalled result holds the input register, and the input
// takes a new word only when the input register is empty or its word moves on.
// Synchronous reset clears handshakes and revision select and resets the state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_loaded_bank_mapper
  import slbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_word_t  req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_word_t rsp,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic         revision_a;
  logic         stage_valid;
  in_word_t     stage;
  logic         fire;
  out_word_t    result;
  core_status_t status;

  assign fire = stage_valid && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      revision_a <= 1'b0;
    end else if (cfg_we) begin
      revision_a <= cfg_wdata;
    end
  end

  slbm_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .take        (fire),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  slbm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .word       (stage),
    .revision_a (revision_a),
    .result     (result),
    .status     (status)
  );

  slbm_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .result    (result),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  `ASSERT_NEXT(a_fire_gives_rsp, clk, rst, fire, rsp_valid)
  `ASSERT_NEXT(a_reset_word_no_load, clk, rst, fire && stage.data_byte[7],
               !rsp.register_loaded && status.control_reg[3] && status.control_reg[2])
  `ASSERT_SAME(a_count_bound, clk, rst, 1'b1, status.shift_count <= SHIFT_LAST)
  `ASSERT_SAME(a_load_clears_count, clk, rst, rsp_valid && rsp.register_loaded,
               status.shift_count == 3'd0)

endmodule

// ===== hdl/slbm_in_reg.sv =====
// ----------------------------------------------------------------------------
// slbm_in_reg
// Input register that holds one write word until the core consumes it.
// ----------------------------------------------------------------------------
module slbm_in_reg
  import slbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  in_word_t req,
  input  logic     take,
  output logic     stage_valid,
  output in_word_t stage
);

  assign req_ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage <= req;
    end
  end

endmodule

// ===== hdl/slbm_core.sv =====
// ----------------------------------------------------------------------------
// slbm_core
// Serial latch, the four mapping registers and the bank decode.
// ----------------------------------------------------------------------------
module slbm_core
  import slbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  in_word_t     word,
  input  logic         revision_a,
  output out_word_t    result,
  output core_status_t status
);

  logic [4:0] control_reg;
  logic [4:0] chr_reg_low;
  logic [4:0] chr_reg_high;
  logic [4:0] prg_reg;
  logic [4:0] shift_latch;
  logic [2:0] shift_count;
  logic [1:0] last_target;

  logic [4:0] control_reg_next;
  logic [4:0] chr_reg_low_next;
  logic [4:0] chr_reg_high_next;
  logic [4:0] prg_reg_next;
  logic [4:0] shift_latch_next;
  logic [2:0] shift_count_next;
  logic [1:0] last_target_next;
  logic       loaded;
  logic [1:0] target;

  assign target = word.addr_nibble[2:1];

  always_comb begin
    logic [4:0] latch_eff;
    logic [2:0] count_eff;
    control_reg_next  = control_reg;
    chr_reg_low_next  = chr_reg_low;
    chr_reg_high_next = chr_reg_high;
    prg_reg_next      = prg_reg;
    shift_latch_next  = shift_latch;
    shift_count_next  = shift_count;
    last_target_next  = last_target;
    loaded            = 1'b0;
    latch_eff         = shift_latch;
    count_eff         = shift_count;
    if (word.data_byte[7]) begin
      shift_latch_next = '0;
      shift_count_next = '0;
      control_reg_next = control_reg | CTRL_RESET_SET;
    end else begin
      if (target != last_target) begin
        latch_eff = '0;
        count_eff = '0;
      end
      last_target_next = target;
      if (count_eff > SHIFT_LAST) begin
        count_eff = '0;
      end
      latch_eff = latch_eff | (5'(word.data_byte[0]) << count_eff);
      count_eff = count_eff + 3'd1;
      if (count_eff == SHIFT_FULL) begin
        unique case (target)
          TGT_CONTROL:  control_reg_next  = latch_eff;
          TGT_CHR_LOW:  chr_reg_low_next  = latch_eff;
          TGT_CHR_HIGH: chr_reg_high_next = latch_eff;
          TGT_PRG:      prg_reg_next      = latch_eff;
          default:      prg_reg_next      = latch_eff;
        endcase
        shift_latch_next = '0;
        shift_count_next = '0;
        loaded           = 1'b1;
      end else begin
        shift_latch_next = latch_eff;
        shift_count_next = count_eff;
      end
    end
  end

  always_comb begin
    logic [3:0] bank_low;
    logic [3:0] bank_high;
    logic       big_bank;
    big_bank = revision_a && prg_reg_next[4];
    if (control_reg_next[3]) begin
      bank_low  = control_reg_next[2] ? prg_reg_next[3:0] : 4'h0;
      bank_high = control_reg_next[2] ? 4'hF : prg_reg_next[3:0];
    end else begin
      bank_low  = {prg_reg_next[3:1], 1'b0};
      bank_high = {prg_reg_next[3:1], 1'b1};
    end
    if (big_bank) begin
      bank_low  = {prg_reg_next[3], bank_low[2:0]};
      bank_high = {prg_reg_next[3], bank_high[2:0]};
    end
    result.prg_bank_low  = bank_low;
    result.prg_bank_high = bank_high;
    if (control_reg_next[4]) begin
      result.chr_bank_low  = chr_reg_low_next;
      result.chr_bank_high = chr_reg_high_next;
    end else begin
      result.chr_bank_low  = {chr_reg_low_next[4:1], 1'b0};
      result.chr_bank_high = {chr_reg_low_next[4:1], 1'b1};
    end
    result.mirror_mode     = control_reg_next[1:0];
    result.ram_enabled     = revision_a || !prg_reg_next[4];
    result.ram_bank        = big_bank && prg_reg_next[3];
    result.register_loaded = loaded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg  <= CTRL_RESET;
      chr_reg_low  <= '0;
      chr_reg_high <= '0;
      prg_reg      <= '0;
      shift_latch  <= '0;
      shift_count  <= '0;
      last_target  <= TGT_CONTROL;
    end else if (fire) begin
      control_reg  <= control_reg_next;
      chr_reg_low  <= chr_reg_low_next;
      chr_reg_high <= chr_reg_high_next;
      prg_reg      <= prg_reg_next;
      shift_latch  <= shift_latch_next;
      shift_count  <= shift_count_next;
      last_target  <= last_target_next;
    end
  end

  assign status.control_reg = control_reg;
  assign status.shift_count = shift_count;

endmodule

// ===== hdl/slbm_out_reg.sv =====
// ----------------------------------------------------------------------------
// slbm_out_reg
// Result register that holds one mapping word until the consumer takes it.
// ----------------------------------------------------------------------------
module slbm_out_reg
  import slbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_word_t result,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_word_t rsp
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= result;
    end
  end

endmodule

// ===== test/serial_loaded_bank_mapper_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_test
// Self-checking bench for the serial-loaded bank mapper. CPU write words go in
// through a valid/ready sender with random gaps. Each accepted word updates a
// local copy of the latch and bank registers, and the bank mapping that it
// yields is queued. A receiver with random stalls takes each result word and
// compares it field by field with the oldest queued mapping. The run covers
// directed register loads, reset writes, target changes, random serial
// traffic under both revision rules, and a long output stall.
// ----------------------------------------------------------------------------
module serial_loaded_bank_mapper_test;
  import slbm_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  in_word_t  req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_word_t rsp;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_request = 0;
  int mismatches = 0;
  int words_sent = 0;

  out_word_t expected_maps[$];

  logic       rev_a;
  logic [4:0] ctrl_q;
  logic [4:0] chr_lo_q;
  logic [4:0] chr_hi_q;
  logic [4:0] prg_q;
  logic [4:0] latch_q;
  logic [2:0] count_q;
  logic [1:0] last_tgt_q;

  serial_loaded_bank_mapper dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  task automatic reset_mapper_model();
    rev_a = 1'b0;
    ctrl_q = CTRL_RESET;
    chr_lo_q = '0;
    chr_hi_q = '0;
    prg_q = '0;
    latch_q = '0;
    count_q = '0;
    last_tgt_q = TGT_CONTROL;
  endtask

  function automatic logic [3:0] rev_a_bank(logic [3:0] bank);
    if (rev_a && prg_q[4]) begin
      return {prg_q[3], bank[2:0]};
    end
    return bank;
  endfunction

  function automatic out_word_t map_after_write(in_word_t w);
    out_word_t  m;
    logic [1:0] tgt;
    logic [3:0] lo_bank;
    logic [3:0] hi_bank;
    tgt = w.addr_nibble[2:1];
    m = '0;
    if (w.data_byte[7]) begin
      latch_q = '0;
      count_q = '0;
      ctrl_q = ctrl_q | CTRL_RESET_SET;
    end else begin
      if (tgt != last_tgt_q) begin
        latch_q = '0;
        count_q = '0;
      end
      last_tgt_q = tgt;
      if (count_q > SHIFT_LAST) begin
        count_q = '0;
      end
      latch_q = latch_q | (5'(w.data_byte[0]) << count_q);
      count_q = count_q + 3'd1;
      if (count_q == SHIFT_FULL) begin
        case (tgt)
          TGT_CONTROL:  ctrl_q = latch_q;
          TGT_CHR_LOW:  chr_lo_q = latch_q;
          TGT_CHR_HIGH: chr_hi_q = latch_q;
          TGT_PRG:      prg_q = latch_q;
        endcase
        latch_q = '0;
        count_q = '0;
        m.register_loaded = 1'b1;
      end
    end
    if (ctrl_q[3]) begin
      lo_bank = ctrl_q[2] ? prg_q[3:0] : 4'h0;
      hi_bank = ctrl_q[2] ? 4'hF : prg_q[3:0];
    end else begin
      lo_bank = {prg_q[3:1], 1'b0};
      hi_bank = {prg_q[3:1], 1'b1};
    end
    m.prg_bank_low = rev_a_bank(lo_bank);
    m.prg_bank_high = rev_a_bank(hi_bank);
    if (ctrl_q[4]) begin
      m.chr_bank_low = chr_lo_q;
      m.chr_bank_high = chr_hi_q;
    end else begin
      m.chr_bank_low = {chr_lo_q[4:1], 1'b0};
      m.chr_bank_high = {chr_lo_q[4:1], 1'b1};
    end
    m.mirror_mode = ctrl_q[1:0];
    m.ram_enabled = rev_a | ~prg_q[4];
    m.ram_bank = rev_a & prg_q[4] & prg_q[3];
    return m;
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 50) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic check_map(out_word_t got);
    out_word_t want;
    if (expected_maps.size() == 0) begin
      report($sformatf("result word %h with no write outstanding", got));
    end else begin
      want = expected_maps.pop_front();
      check_field("prg_bank_low", 8'(got.prg_bank_low), 8'(want.prg_bank_low));
      check_field("prg_bank_high", 8'(got.prg_bank_high), 8'(want.prg_bank_high));
      check_field("chr_bank_low", 8'(got.chr_bank_low), 8'(want.chr_bank_low));
      check_field("chr_bank_high", 8'(got.chr_bank_high), 8'(want.chr_bank_high));
      check_field("mirror_mode", 8'(got.mirror_mode), 8'(want.mirror_mode));
      check_field("ram_enabled", 8'(got.ram_enabled), 8'(want.ram_enabled));
      check_field("ram_bank", 8'(got.ram_bank), 8'(want.ram_bank));
      check_field("register_loaded", 8'(got.register_loaded),
                  8'(want.register_loaded));
    end
  endtask

  task automatic send_write(in_word_t w);
    int gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!req_ready);
    expected_maps.push_back(map_after_write(w));
    words_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  function automatic in_word_t serial_word(logic [1:0] tgt, logic b);
    in_word_t w;
    w.addr_nibble = {($urandom_range(0, 7) != 0), tgt, 1'($urandom_range(0, 1))};
    w.data_byte = {1'b0, 6'($urandom), b};
    return w;
  endfunction

  function automatic in_word_t reset_word();
    in_word_t w;
    w.addr_nibble = 4'($urandom);
    w.data_byte = {1'b1, 7'($urandom)};
    return w;
  endfunction

  task automatic load_register(logic [1:0] tgt, logic [4:0] value);
    for (int i = 0; i < 5; i++) begin
      send_write(serial_word(tgt, value[i]));
    end
  endtask

  task automatic write_revision_select(logic value);
    stop_sending();
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    rev_a = value;
  endtask

  task automatic test_register_loads();
    load_register(TGT_CONTROL, 5'h1F);
    load_register(TGT_CHR_LOW, 5'h00);
    load_register(TGT_CHR_HIGH, 5'h1F);
    load_register(TGT_PRG, 5'h10);
  endtask

  // A reset write is followed by a partial load that a change of target cuts short.
  task automatic test_special_cases();
    send_write('{addr_nibble: 4'hF, data_byte: 8'hFF});
    send_write('{addr_nibble: 4'h0, data_byte: 8'h7F});
    send_write('{addr_nibble: 4'h6, data_byte: 8'h00});
    send_write('{addr_nibble: 4'hF, data_byte: 8'h00});
  endtask

  task automatic test_random_traffic(int count);
    int         stop_at;
    int         kind;
    int         partial;
    logic [1:0] tgt;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) begin
        send_idle = 1'($urandom_range(0, 1));
        recv_idle = 1'($urandom_range(0, 1));
      end
      kind = $urandom_range(0, 9);
      tgt = 2'($urandom);
      if (kind == 0) begin
        send_write(reset_word());
      end else if (kind == 1) begin
        partial = $urandom_range(1, 4);
        repeat (partial) send_write(serial_word(tgt, 1'($urandom)));
      end else begin
        load_register(tgt, 5'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) begin
      load_register(2'($urandom), 5'($urandom));
    end
    send_idle = 1'b1;
  endtask

  initial begin : receiver
    int stall;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        rsp_ready <= 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      stall = recv_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      check_map(rsp);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("serial_loaded_bank_mapper_test failed");
    $finish;
  end

  initial begin
    reset_mapper_model();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_register_loads();
    test_special_cases();
    test_random_traffic(600);
    write_revision_select(1'b1);
    test_random_traffic(500);
    test_backpressure();
    write_revision_select(1'b0);
    test_random_traffic(350);
    write_revision_select(1'b1);
    test_random_traffic(300);
    stop_sending();
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("serial_loaded_bank_mapper_test passed");
    end else begin
      $display("serial_loaded_bank_mapper_test failed");
    end
    $finish;
  end

endmodule
